[rtl/core/bhpq_pkg.sv]
// Package for the binary heap priority queue: sizes, opcodes, status codes,
// sequencer states and the memory request bundle. No dependencies.
`timescale 1ns / 1ps

package bhpq_pkg;

  localparam int CAPACITY = 1024;
  localparam int KEY_W    = 32;
  localparam int CNT_W    = 11;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int FILL_W   = $clog2(CAPACITY + 1);
  localparam int CHILD_W  = ADDR_W + 2;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_EXTRACT = 2'd1,
    OP_PEEK    = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GET_ROOT,
    S_GET_LAST,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RDL,
    S_DN_RDR,
    S_DN_CMPR
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [KEY_W-1:0]  wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

[rtl/core/bhpq_key_ram.sv]
// Key store of the heap: one write port and one read port with registered
// read data. Depends on bhpq_pkg.
`timescale 1ns / 1ps

module bhpq_key_ram (
  input  logic                           clk,
  input  bhpq_pkg::mem_req_t             req,
  output logic [bhpq_pkg::KEY_W-1:0]     q
);

  logic [bhpq_pkg::KEY_W-1:0] mem [bhpq_pkg::CAPACITY];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      q <= mem[req.raddr];
    end
  end

endmodule

[rtl/core/bhpq_rank.sv]
// Shared key comparator: tells whether key a must sit above key b under the
// selected heap order. Depends on bhpq_pkg.
`timescale 1ns / 1ps

module bhpq_rank (
  input  logic signed [bhpq_pkg::KEY_W-1:0] a,
  input  logic signed [bhpq_pkg::KEY_W-1:0] b,
  input  logic                              min_order,
  output logic                              above
);

  assign above = min_order ? (a < b) : (a > b);

endmodule

[rtl/core/bhpq_ctrl.sv]
// Heap sequencer: request decode, sift-up and sift-down walks over the key
// store with one shared comparator, fill count and result registers.
// Depends on bhpq_pkg and bhpq_rank.
`timescale 1ns / 1ps

module bhpq_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [1:0]                    in_opcode,
  input  logic signed [31:0]            in_key,
  output logic                          busy,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_min_order,
  output logic                          out_valid,
  output logic signed [31:0]            out_root_value,
  output logic [1:0]                    out_status,
  output logic [bhpq_pkg::CNT_W-1:0]    out_count,
  output bhpq_pkg::mem_req_t            mem_req,
  input  logic [bhpq_pkg::KEY_W-1:0]    mem_q
);

  localparam int AW = bhpq_pkg::ADDR_W;
  localparam int FW = bhpq_pkg::FILL_W;
  localparam int CW = bhpq_pkg::CHILD_W;
  localparam int KW = bhpq_pkg::KEY_W;

  bhpq_pkg::state_t  state_r, state_nxt;
  logic [FW-1:0]     fill_r, fill_nxt;
  logic              min_order_r, min_order_nxt;
  logic [AW-1:0]     pos_r, pos_nxt;
  logic [KW-1:0]     cur_key_r, cur_key_nxt;
  logic [KW-1:0]     best_key_r, best_key_nxt;
  logic              best_left_r, best_left_nxt;
  logic [KW-1:0]     root_r, root_nxt;
  logic              extract_r, extract_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [KW-1:0]     out_root_r, out_root_nxt;
  bhpq_pkg::status_t out_status_r, out_status_nxt;
  logic [bhpq_pkg::CNT_W-1:0] out_count_r, out_count_nxt;

  logic [KW-1:0] cmp_a, cmp_b;
  logic          cmp_above;
  logic [CW-1:0] lc, rc, fill_ext;
  logic [AW-1:0] parent;
  logic          full;

  bhpq_rank u_rank (
    .a         (cmp_a),
    .b         (cmp_b),
    .min_order (min_order_r),
    .above     (cmp_above)
  );

  assign lc       = (CW'(pos_r) << 1) + CW'(1);
  assign rc       = (CW'(pos_r) << 1) + CW'(2);
  assign fill_ext = CW'(fill_r);
  assign parent   = AW'((pos_r - AW'(1)) >> 1);
  assign full     = (fill_r == FW'(bhpq_pkg::CAPACITY));

  assign busy      = (state_r != bhpq_pkg::S_IDLE);
  assign cfg_ready = !busy;

  assign out_valid      = out_valid_r;
  assign out_root_value = out_root_r;
  assign out_status     = out_status_r;
  assign out_count      = out_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bhpq_pkg::S_IDLE;
      fill_r      <= '0;
      min_order_r <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      min_order_r <= min_order_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    cur_key_r    <= cur_key_nxt;
    best_key_r   <= best_key_nxt;
    best_left_r  <= best_left_nxt;
    root_r       <= root_nxt;
    extract_r    <= extract_nxt;
    out_root_r   <= out_root_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    min_order_nxt  = min_order_r;
    pos_nxt        = pos_r;
    cur_key_nxt    = cur_key_r;
    best_key_nxt   = best_key_r;
    best_left_nxt  = best_left_r;
    root_nxt       = root_r;
    extract_nxt    = extract_r;
    out_valid_nxt  = 1'b0;
    out_root_nxt   = out_root_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    mem_req        = '0;
    cmp_a          = cur_key_r;
    cmp_b          = mem_q;

    if (cfg_valid && cfg_ready) begin
      min_order_nxt = cfg_min_order;
    end

    case (state_r)
      bhpq_pkg::S_IDLE: begin
        if (start) begin
          case (in_opcode)
            bhpq_pkg::OP_INSERT: begin
              if (full) begin
                out_valid_nxt  = 1'b1;
                out_root_nxt   = '0;
                out_status_nxt = bhpq_pkg::ST_FULL;
                out_count_nxt  = bhpq_pkg::CNT_W'(fill_r);
              end else begin
                cur_key_nxt = in_key;
                pos_nxt     = AW'(fill_r);
                fill_nxt    = fill_r + FW'(1);
                extract_nxt = 1'b0;
                state_nxt   = bhpq_pkg::S_UP_RD;
              end
            end
            bhpq_pkg::OP_EXTRACT, bhpq_pkg::OP_PEEK: begin
              if (fill_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_root_nxt   = '0;
                out_status_nxt = bhpq_pkg::ST_EMPTY;
                out_count_nxt  = '0;
              end else begin
                mem_req.re    = 1'b1;
                mem_req.raddr = '0;
                extract_nxt   = (in_opcode == bhpq_pkg::OP_EXTRACT);
                state_nxt     = bhpq_pkg::S_GET_ROOT;
              end
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_root_nxt   = '0;
              out_status_nxt = bhpq_pkg::ST_OK;
              out_count_nxt  = bhpq_pkg::CNT_W'(fill_r);
            end
          endcase
        end
      end

      bhpq_pkg::S_GET_ROOT: begin
        root_nxt = mem_q;
        if (extract_r) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = AW'(fill_r - FW'(1));
          state_nxt     = bhpq_pkg::S_GET_LAST;
        end else begin
          out_valid_nxt  = 1'b1;
          out_root_nxt   = mem_q;
          out_status_nxt = bhpq_pkg::ST_OK;
          out_count_nxt  = bhpq_pkg::CNT_W'(fill_r);
          state_nxt      = bhpq_pkg::S_IDLE;
        end
      end

      bhpq_pkg::S_GET_LAST: begin
        cur_key_nxt = mem_q;
        fill_nxt    = fill_r - FW'(1);
        pos_nxt     = '0;
        state_nxt   = bhpq_pkg::S_DN_RDL;
      end

      bhpq_pkg::S_UP_RD: begin
        if (pos_r == '0) begin
          mem_req.we     = 1'b1;
          mem_req.waddr  = pos_r;
          mem_req.wdata  = cur_key_r;
          out_valid_nxt  = 1'b1;
          out_root_nxt   = '0;
          out_status_nxt = bhpq_pkg::ST_OK;
          out_count_nxt  = bhpq_pkg::CNT_W'(fill_r);
          state_nxt      = bhpq_pkg::S_IDLE;
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = parent;
          state_nxt     = bhpq_pkg::S_UP_CMP;
        end
      end

      bhpq_pkg::S_UP_CMP: begin
        cmp_a         = cur_key_r;
        cmp_b         = mem_q;
        mem_req.we    = 1'b1;
        mem_req.waddr = pos_r;
        if (cmp_above) begin
          mem_req.wdata = mem_q;
          pos_nxt       = parent;
          state_nxt     = bhpq_pkg::S_UP_RD;
        end else begin
          mem_req.wdata  = cur_key_r;
          out_valid_nxt  = 1'b1;
          out_root_nxt   = '0;
          out_status_nxt = bhpq_pkg::ST_OK;
          out_count_nxt  = bhpq_pkg::CNT_W'(fill_r);
          state_nxt      = bhpq_pkg::S_IDLE;
        end
      end

      bhpq_pkg::S_DN_RDL: begin
        if (lc >= fill_ext) begin
          mem_req.we     = 1'b1;
          mem_req.waddr  = pos_r;
          mem_req.wdata  = cur_key_r;
          out_valid_nxt  = 1'b1;
          out_root_nxt   = root_r;
          out_status_nxt = bhpq_pkg::ST_OK;
          out_count_nxt  = bhpq_pkg::CNT_W'(fill_r);
          state_nxt      = bhpq_pkg::S_IDLE;
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = AW'(lc);
          state_nxt     = bhpq_pkg::S_DN_RDR;
        end
      end

      bhpq_pkg::S_DN_RDR: begin
        cmp_a         = mem_q;
        cmp_b         = cur_key_r;
        best_left_nxt = cmp_above;
        best_key_nxt  = cmp_above ? mem_q : cur_key_r;
        if (rc < fill_ext) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = AW'(rc);
          state_nxt     = bhpq_pkg::S_DN_CMPR;
        end else if (cmp_above) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = pos_r;
          mem_req.wdata = mem_q;
          pos_nxt       = AW'(lc);
          state_nxt     = bhpq_pkg::S_DN_RDL;
        end else begin
          mem_req.we     = 1'b1;
          mem_req.waddr  = pos_r;
          mem_req.wdata  = cur_key_r;
          out_valid_nxt  = 1'b1;
          out_root_nxt   = root_r;
          out_status_nxt = bhpq_pkg::ST_OK;
          out_count_nxt  = bhpq_pkg::CNT_W'(fill_r);
          state_nxt      = bhpq_pkg::S_IDLE;
        end
      end

      bhpq_pkg::S_DN_CMPR: begin
        cmp_a         = mem_q;
        cmp_b         = best_key_r;
        mem_req.we    = 1'b1;
        mem_req.waddr = pos_r;
        if (cmp_above) begin
          mem_req.wdata = mem_q;
          pos_nxt       = AW'(rc);
          state_nxt     = bhpq_pkg::S_DN_RDL;
        end else if (best_left_r) begin
          mem_req.wdata = best_key_r;
          pos_nxt       = AW'(lc);
          state_nxt     = bhpq_pkg::S_DN_RDL;
        end else begin
          mem_req.wdata  = cur_key_r;
          out_valid_nxt  = 1'b1;
          out_root_nxt   = root_r;
          out_status_nxt = bhpq_pkg::ST_OK;
          out_count_nxt  = bhpq_pkg::CNT_W'(fill_r);
          state_nxt      = bhpq_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = bhpq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/binary_heap_priority_queue.sv]
// Top level of the binary heap priority queue: sequencer plus key store,
// with interface checks. Depends on bhpq_pkg, bhpq_ctrl and bhpq_key_ram.
//
//   channel  | handshake           | beat contents
//   ---------+---------------------+-------------------------------------
//   input    | start, busy         | in_opcode, in_key
//   result   | out_valid (strobe)  | out_root_value, out_status, out_count
//   config   | cfg_valid/cfg_ready | cfg_min_order
//
// Requests are taken when start is high and busy is low. Rejected, empty and
// unknown requests give their beat in the cycle after acceptance, a peek after
// S_GET_ROOT; an insert climbs via S_UP_RD/S_UP_CMP per level, an extract reads
// root and last key, then sinks via S_DN_RDL/S_DN_RDR/S_DN_CMPR per level, all
// over the single read port of the store. The beat cannot be stalled. Reset
// empties the heap and selects min order; the store itself is not cleared.
`timescale 1ns / 1ps

module binary_heap_priority_queue (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 in_opcode,
  input  logic signed [31:0]         in_key,
  output logic                       out_valid,
  output logic signed [31:0]         out_root_value,
  output logic [1:0]                 out_status,
  output logic [bhpq_pkg::CNT_W-1:0] out_count,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_min_order
);

  bhpq_pkg::mem_req_t         mem_req;
  logic [bhpq_pkg::KEY_W-1:0] mem_q;

  bhpq_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .in_opcode      (in_opcode),
    .in_key         (in_key),
    .busy           (busy),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_min_order  (cfg_min_order),
    .out_valid      (out_valid),
    .out_root_value (out_root_value),
    .out_status     (out_status),
    .out_count      (out_count),
    .mem_req        (mem_req),
    .mem_q          (mem_q)
  );

  bhpq_key_ram u_ram (
    .clk (clk),
    .req (mem_req),
    .q   (mem_q)
  );

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_valid)
    else $error("accepted request neither started work nor gave a result");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result beat while the sequencer is still working");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == bhpq_pkg::ST_FULL |->
      out_count == bhpq_pkg::CNT_W'(bhpq_pkg::CAPACITY))
    else $error("full status without a full heap");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == bhpq_pkg::ST_EMPTY |->
      out_count == '0 && out_root_value == '0)
    else $error("empty status with keys held or a root value");

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for binary_heap_priority_queue: a driver and a monitor
// checked against a behavioral heap that predicts every result beat.
// Depends on bhpq_pkg and the RTL of the heap priority queue.

module tb;

  localparam int KEY_W    = bhpq_pkg::KEY_W;
  localparam int CNT_W    = bhpq_pkg::CNT_W;
  localparam int CAPACITY = bhpq_pkg::CAPACITY;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 64;

  typedef struct {
    bit                      order_write;
    bit                      order_min;
    logic [1:0]              opcode;
    logic signed [KEY_W-1:0] key;
  } request_t;

  typedef struct {
    logic signed [KEY_W-1:0] root;
    logic [1:0]              status;
    logic [CNT_W-1:0]        count;
  } reply_t;

  logic                    clk;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [1:0]              in_opcode = 2'd0;
  logic signed [KEY_W-1:0] in_key = '0;
  logic                    out_valid;
  logic signed [KEY_W-1:0] out_root_value;
  logic [1:0]              out_status;
  logic [CNT_W-1:0]        out_count;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic                    cfg_min_order = 1'b1;

  request_t request_q[$];
  reply_t   reply_q[$];

  // Behavioral heap used to predict each result beat.
  logic signed [KEY_W-1:0] heap_keys [CAPACITY];
  int                      heap_fill = 0;
  bit                      min_first = 1'b1;

  int       err_count = 0;
  int       cycle_count = 0;
  int       gap_left = 0;
  int       burst_left = 0;
  logic     next_start;
  logic     next_cfg;
  request_t head;
  reply_t   want;

  binary_heap_priority_queue u_top (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic flag(string msg);
    $display("tb mismatch: %s", msg);
    err_count++;
  endtask

  function automatic bit ranks_above(logic signed [KEY_W-1:0] a, logic signed [KEY_W-1:0] b);
    return min_first ? (a < b) : (a > b);
  endfunction

  function automatic void swap_keys(int i, int j);
    logic signed [KEY_W-1:0] t;
    t = heap_keys[i];
    heap_keys[i] = heap_keys[j];
    heap_keys[j] = t;
  endfunction

  function automatic reply_t apply_request(logic [1:0] opcode, logic signed [KEY_W-1:0] key);
    reply_t r;
    int     pos;
    int     parent;
    int     best;
    r.root   = '0;
    r.status = bhpq_pkg::ST_OK;
    case (opcode)
      bhpq_pkg::OP_INSERT: begin
        if (heap_fill >= CAPACITY) begin
          r.status = bhpq_pkg::ST_FULL;
        end else begin
          heap_keys[heap_fill] = key;
          pos = heap_fill;
          heap_fill++;
          while (pos > 0) begin
            parent = (pos - 1) / 2;
            if (!ranks_above(heap_keys[pos], heap_keys[parent])) break;
            swap_keys(pos, parent);
            pos = parent;
          end
        end
      end
      bhpq_pkg::OP_EXTRACT, bhpq_pkg::OP_PEEK: begin
        if (heap_fill == 0) begin
          r.status = bhpq_pkg::ST_EMPTY;
        end else begin
          r.root = heap_keys[0];
          if (opcode == bhpq_pkg::OP_EXTRACT) begin
            heap_keys[0] = heap_keys[heap_fill - 1];
            heap_fill--;
            pos = 0;
            while (1) begin
              best = pos;
              if (2 * pos + 1 < heap_fill && ranks_above(heap_keys[2 * pos + 1], heap_keys[best]))
                best = 2 * pos + 1;
              if (2 * pos + 2 < heap_fill && ranks_above(heap_keys[2 * pos + 2], heap_keys[best]))
                best = 2 * pos + 2;
              if (best == pos) break;
              swap_keys(pos, best);
              pos = best;
            end
          end
        end
      end
      default: begin
      end
    endcase
    r.count = CNT_W'(heap_fill);
    return r;
  endfunction

  function automatic int pick_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if ($urandom_range(0, 11) == 0) return $urandom_range(8, 40);
    return $urandom_range(0, 2);
  endfunction

  function automatic logic signed [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2, 3: return $signed($urandom_range(0, 15)) - 8;
      default: return $urandom();
    endcase
  endfunction

  task automatic queue_op(logic [1:0] opcode, logic signed [KEY_W-1:0] key);
    request_t r;
    r.order_write = 1'b0;
    r.order_min   = 1'b0;
    r.opcode      = opcode;
    r.key         = key;
    request_q.push_back(r);
  endtask

  task automatic queue_order(bit order_min);
    request_t r;
    r.order_write = 1'b1;
    r.order_min   = order_min;
    r.opcode      = OP_NONE;
    r.key         = '0;
    request_q.push_back(r);
  endtask

  task automatic queue_random(int n, int w_ins, int w_ext, int w_peek);
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < w_ins) queue_op(bhpq_pkg::OP_INSERT, pick_key());
      else if (pick < w_ins + w_ext) queue_op(bhpq_pkg::OP_EXTRACT, $urandom());
      else if (pick < w_ins + w_ext + w_peek) queue_op(bhpq_pkg::OP_PEEK, $urandom());
      else queue_op(OP_NONE, $urandom());
    end
  endtask

  task automatic settle();
    while (request_q.size() > 0 || reply_q.size() > 0 || start || cfg_valid) @(negedge clk);
  endtask

  // Driver: presents one request beat at a time and predicts its result on acceptance.
  always @(posedge clk) begin
    if (rst_n) begin
      next_start = start;
      next_cfg   = cfg_valid;
      if (start && !busy) begin
        reply_q.push_back(apply_request(in_opcode, in_key));
        next_start = 1'b0;
        gap_left   = pick_gap();
      end
      if (cfg_valid && cfg_ready) begin
        min_first = cfg_min_order;
        next_cfg  = 1'b0;
      end
      if (!next_start && !next_cfg && request_q.size() > 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (request_q[0].order_write) begin
          if (reply_q.size() == 0 && !busy) begin
            head = request_q.pop_front();
            cfg_min_order <= head.order_min;
            next_cfg = 1'b1;
          end
        end else begin
          head = request_q.pop_front();
          in_opcode <= head.opcode;
          in_key    <= head.key;
          next_start = 1'b1;
        end
      end
      start     <= next_start;
      cfg_valid <= next_cfg;
    end
  end

  // Monitor: every result beat must match the oldest predicted result.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (reply_q.size() == 0) begin
        flag($sformatf("unexpected beat root=%0d status=%0d count=%0d",
                       out_root_value, out_status, out_count));
      end else begin
        want = reply_q.pop_front();
        if (out_root_value !== want.root)
          flag($sformatf("root_value got %0d exp %0d", out_root_value, want.root));
        if (out_status !== want.status)
          flag($sformatf("status got %0d exp %0d", out_status, want.status));
        if (out_count !== want.count)
          flag($sformatf("count got %0d exp %0d", out_count, want.count));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    int n;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    queue_order(1'b1);
    queue_op(bhpq_pkg::OP_PEEK, 32'h7FFF_FFFF);
    queue_op(bhpq_pkg::OP_EXTRACT, 32'h8000_0000);
    queue_op(OP_NONE, 32'hFFFF_FFFF);
    queue_op(bhpq_pkg::OP_INSERT, 32'h7FFF_FFFF);
    queue_op(bhpq_pkg::OP_INSERT, 32'h8000_0000);
    queue_op(bhpq_pkg::OP_INSERT, 32'h0000_0000);
    queue_op(bhpq_pkg::OP_INSERT, 32'hFFFF_FFFF);
    queue_op(bhpq_pkg::OP_INSERT, 32'h0000_0001);
    queue_op(bhpq_pkg::OP_INSERT, 32'hFFFF_FFFF);
    queue_op(bhpq_pkg::OP_INSERT, 32'h8000_0000);
    queue_op(bhpq_pkg::OP_PEEK, 32'h0000_0000);
    queue_op(OP_NONE, 32'h0000_0000);
    for (int i = 0; i < 8; i++) queue_op(bhpq_pkg::OP_EXTRACT, $urandom());
    queue_op(bhpq_pkg::OP_PEEK, $urandom());

    queue_random(200, 60, 25, 10);
    // The order flips while keys are held, so later sifts run on a mixed heap.
    queue_order(1'b0);
    queue_random(200, 35, 45, 15);

    settle();
    queue_order(1'b1);
    n = CAPACITY - heap_fill + 6;
    for (int i = 0; i < n; i++) begin
      queue_op(bhpq_pkg::OP_INSERT, pick_key());
      if (i % 64 == 0) queue_op(bhpq_pkg::OP_PEEK, $urandom());
    end
    queue_order(1'b0);
    queue_random(200, 20, 65, 10);
    queue_order(1'b1);
    queue_random(150, 50, 35, 10);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/bhpq_pkg.sv
rtl/core/bhpq_key_ram.sv
rtl/core/bhpq_rank.sv
rtl/core/bhpq_ctrl.sv
rtl/core/binary_heap_priority_queue.sv
verif/tb.sv
